### sv/c6502_pkg.sv
`default_nettype none
package c6502_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0, OP_AND = 6'd1, OP_ASL = 6'd2, OP_ASLA = 6'd3, OP_BIT = 6'd4,
      OP_BPL = 6'd5, OP_BMI = 6'd6, OP_BVC = 6'd7, OP_BVS = 6'd8, OP_BCC = 6'd9,
      OP_BCS = 6'd10, OP_BNE = 6'd11, OP_BEQ = 6'd12, OP_BRK = 6'd13, OP_CMP = 6'd14,
      OP_CPX = 6'd15, OP_CPY = 6'd16, OP_DEC = 6'd17, OP_EOR = 6'd18, OP_CLC = 6'd19,
      OP_SEC = 6'd20, OP_CLI = 6'd21, OP_SEI = 6'd22, OP_CLV = 6'd23, OP_CLD = 6'd24,
      OP_SED = 6'd25, OP_INC = 6'd26, OP_JMP = 6'd27, OP_JSR = 6'd28, OP_LDA = 6'd29,
      OP_LDX = 6'd30, OP_LDY = 6'd31, OP_LSR = 6'd32, OP_LSRA = 6'd33, OP_NOP = 6'd34,
      OP_ORA = 6'd35, OP_TAX = 6'd36, OP_TXA = 6'd37, OP_DEX = 6'd38, OP_INX = 6'd39,
      OP_TAY = 6'd40, OP_TYA = 6'd41, OP_DEY = 6'd42, OP_INY = 6'd43, OP_ROL = 6'd44,
      OP_ROLA = 6'd45, OP_ROR = 6'd46, OP_RORA = 6'd47, OP_RTI = 6'd48, OP_RTS = 6'd49,
      OP_SBC = 6'd50, OP_STA = 6'd51, OP_TXS = 6'd52, OP_TSX = 6'd53, OP_PHA = 6'd54,
      OP_PLA = 6'd55, OP_PHP = 6'd56, OP_PLP = 6'd57, OP_STX = 6'd58, OP_STY = 6'd59
   } op_type;

   localparam logic [7:0] FLAG_N = 8'h80;
   localparam logic [7:0] FLAG_V = 8'h40;
   localparam logic [7:0] FLAG_B = 8'h10;
   localparam logic [7:0] FLAG_C = 8'h01;
   localparam logic [7:0] SP_RESET = 8'hFD;
   localparam logic [7:0] P_RESET = 8'h24;
   localparam logic [7:0] STACK_PAGE = 8'h01;

   localparam int QDEPTH = 2;

   // one queued instruction
   typedef struct packed {
      logic [5:0]  operation;
      logic [15:0] operand_address;
      logic [7:0]  memory_byte;
      logic [7:0]  stack_byte_1;
      logic [7:0]  stack_byte_2;
      logic [7:0]  stack_byte_3;
      logic [15:0] current_pc;
   } instr_type;

   typedef struct packed {
      logic        write_valid;
      logic [15:0] write_address;
      logic [7:0]  write_data;
      logic        last;
      logic [15:0] next_pc;
      logic [7:0]  acc_value;
      logic [7:0]  index_x_value;
      logic [7:0]  index_y_value;
      logic [7:0]  stack_pointer_value;
      logic [7:0]  status_value;
      logic        irq_request;
   } result_type;

endpackage
`default_nettype wire

### sv/c6502_front.sv
`default_nettype none
// Two-entry queue toward the execute stage.
module c6502_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  c6502_pkg::instr_type   in_item,
   output logic                   out_valid,
   input  wire                    out_ready,
   output c6502_pkg::instr_type   out_item
);
   c6502_pkg::instr_type q_ff [c6502_pkg::QDEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = q_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= in_item;
   end
endmodule
`default_nettype wire

### sv/c6502_exec.sv
`default_nettype none
// Executes one instruction per cycle while the output accepts; JSR and BRK (I clear) emit one write per beat.
module c6502_exec (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  c6502_pkg::instr_type   in_item,
   output logic                   out_valid,
   input  wire                    out_ready,
   output c6502_pkg::result_type  out_item
);
   logic [7:0] a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic [1:0] beat_ff, beat_in;
   logic       ov_ff;
   c6502_pkg::result_type res_ff, res_in;
   logic       load;

   // decode scratch
   logic [7:0]  m, v, r, s, pn;
   logic [8:0]  sum;
   logic [15:0] nxt, t;
   logic [1:0]  nw;
   logic        irq, cin;
   logic [7:0]  wd0, wd1, wd2;
   logic [15:0] wa0, wa1, wa2;
   logic [7:0]  cmpreg;
   logic        docmp;
   c6502_pkg::op_type op;

   assign in_ready = (!ov_ff || out_ready) && in_valid && (beat_ff == nw - 2'd1 || nw == 2'd0);
   assign load = (!ov_ff || out_ready) && in_valid;
   assign out_valid = ov_ff;
   assign out_item = res_ff;

   always_comb begin
      op = c6502_pkg::op_type'(in_item.operation);
      m = in_item.memory_byte;
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; pn = p_ff;
      nxt = in_item.current_pc; nw = 2'd0; irq = 1'b0;
      wa0 = '0; wa1 = '0; wa2 = '0; wd0 = '0; wd1 = '0; wd2 = '0;
      v = 8'd0; t = 16'd0; cmpreg = a_ff; docmp = 1'b0;
      cin = p_ff[0];
      s = (op == c6502_pkg::OP_SBC) ? ~m : m;
      sum = {1'b0, a_ff} + {1'b0, s} + {8'd0, cin};
      r = sum[7:0];
      unique case (op)
         c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
            a_in = r; pn[0] = sum[8];
            pn[6] = ~(a_ff[7] ^ s[7]) & (a_ff[7] ^ r[7]);
            pn[7] = r[7]; pn[1] = (r == 8'd0);
         end
         c6502_pkg::OP_AND: a_in = a_ff & m;
         c6502_pkg::OP_EOR: a_in = a_ff ^ m;
         c6502_pkg::OP_ORA: a_in = a_ff | m;
         c6502_pkg::OP_ASL, c6502_pkg::OP_DEC, c6502_pkg::OP_INC, c6502_pkg::OP_LSR,
         c6502_pkg::OP_ROL, c6502_pkg::OP_ROR: begin
            unique case (op)
               c6502_pkg::OP_ASL: begin v = {m[6:0], 1'b0}; pn[0] = m[7]; end
               c6502_pkg::OP_DEC: v = m - 8'd1;
               c6502_pkg::OP_INC: v = m + 8'd1;
               c6502_pkg::OP_LSR: begin v = {1'b0, m[7:1]}; pn[0] = m[0]; end
               c6502_pkg::OP_ROL: begin v = {m[6:0], p_ff[0]}; pn[0] = m[7]; end
               default: begin v = {p_ff[0], m[7:1]}; pn[0] = m[0]; end
            endcase
            pn[7] = v[7]; pn[1] = (v == 8'd0);
            nw = 2'd1; wa0 = in_item.operand_address; wd0 = v;
         end
         c6502_pkg::OP_ASLA: begin a_in = {a_ff[6:0], 1'b0}; pn[0] = a_ff[7]; end
         c6502_pkg::OP_LSRA: begin a_in = {1'b0, a_ff[7:1]}; pn[0] = a_ff[0]; end
         c6502_pkg::OP_ROLA: begin a_in = {a_ff[6:0], p_ff[0]}; pn[0] = a_ff[7]; end
         c6502_pkg::OP_RORA: begin a_in = {p_ff[0], a_ff[7:1]}; pn[0] = a_ff[0]; end
         c6502_pkg::OP_BIT: begin pn[7] = m[7]; pn[6] = m[6]; pn[1] = ((a_ff & m) == 8'd0); end
         c6502_pkg::OP_BPL: if (!p_ff[7]) nxt = in_item.operand_address;
         c6502_pkg::OP_BMI: if (p_ff[7]) nxt = in_item.operand_address;
         c6502_pkg::OP_BVC: if (!p_ff[6]) nxt = in_item.operand_address;
         c6502_pkg::OP_BVS: if (p_ff[6]) nxt = in_item.operand_address;
         c6502_pkg::OP_BCC: if (!p_ff[0]) nxt = in_item.operand_address;
         c6502_pkg::OP_BCS: if (p_ff[0]) nxt = in_item.operand_address;
         c6502_pkg::OP_BNE: if (!p_ff[1]) nxt = in_item.operand_address;
         c6502_pkg::OP_BEQ: if (p_ff[1]) nxt = in_item.operand_address;
         c6502_pkg::OP_BRK: if (!p_ff[2]) begin
            t = in_item.current_pc + 16'd1;
            nw = 2'd3;
            wa0 = {c6502_pkg::STACK_PAGE, sp_ff}; wd0 = t[15:8];
            wa1 = {c6502_pkg::STACK_PAGE, sp_ff - 8'd1}; wd1 = t[7:0];
            wa2 = {c6502_pkg::STACK_PAGE, sp_ff - 8'd2}; wd2 = p_ff;
            sp_in = sp_ff - 8'd3; pn[2] = 1'b1; irq = 1'b1;
         end
         c6502_pkg::OP_CMP: begin docmp = 1'b1; cmpreg = a_ff; end
         c6502_pkg::OP_CPX: begin docmp = 1'b1; cmpreg = x_ff; end
         c6502_pkg::OP_CPY: begin docmp = 1'b1; cmpreg = y_ff; end
         c6502_pkg::OP_CLC: pn[0] = 1'b0;
         c6502_pkg::OP_SEC: pn[0] = 1'b1;
         c6502_pkg::OP_CLI: pn[2] = 1'b0;
         c6502_pkg::OP_SEI: pn[2] = 1'b1;
         c6502_pkg::OP_CLV: pn[6] = 1'b0;
         c6502_pkg::OP_CLD: pn[3] = 1'b0;
         c6502_pkg::OP_SED: pn[3] = 1'b1;
         c6502_pkg::OP_JMP: nxt = in_item.operand_address;
         c6502_pkg::OP_JSR: begin
            t = in_item.current_pc - 16'd1;
            nw = 2'd2;
            wa0 = {c6502_pkg::STACK_PAGE, sp_ff}; wd0 = t[15:8];
            wa1 = {c6502_pkg::STACK_PAGE, sp_ff - 8'd1}; wd1 = t[7:0];
            sp_in = sp_ff - 8'd2; nxt = in_item.operand_address;
         end
         c6502_pkg::OP_LDA: a_in = m;
         c6502_pkg::OP_LDX: x_in = m;
         c6502_pkg::OP_LDY: y_in = m;
         c6502_pkg::OP_TAX: x_in = a_ff;
         c6502_pkg::OP_TXA: a_in = x_ff;
         c6502_pkg::OP_DEX: x_in = x_ff - 8'd1;
         c6502_pkg::OP_INX: x_in = x_ff + 8'd1;
         c6502_pkg::OP_TAY: y_in = a_ff;
         c6502_pkg::OP_TYA: a_in = y_ff;
         c6502_pkg::OP_DEY: y_in = y_ff - 8'd1;
         c6502_pkg::OP_INY: y_in = y_ff + 8'd1;
         c6502_pkg::OP_RTI: begin
            pn = in_item.stack_byte_1; sp_in = sp_ff + 8'd3;
            nxt = {in_item.stack_byte_3, in_item.stack_byte_2};
         end
         c6502_pkg::OP_RTS: begin
            sp_in = sp_ff + 8'd2;
            nxt = {in_item.stack_byte_2, in_item.stack_byte_1} + 16'd1;
         end
         c6502_pkg::OP_STA: begin nw = 2'd1; wa0 = in_item.operand_address; wd0 = a_ff; end
         c6502_pkg::OP_STX: begin nw = 2'd1; wa0 = in_item.operand_address; wd0 = x_ff; end
         c6502_pkg::OP_STY: begin nw = 2'd1; wa0 = in_item.operand_address; wd0 = y_ff; end
         c6502_pkg::OP_TXS: sp_in = x_ff;
         c6502_pkg::OP_TSX: x_in = sp_ff;
         c6502_pkg::OP_PHA, c6502_pkg::OP_PHP: begin
            nw = 2'd1; wa0 = {c6502_pkg::STACK_PAGE, sp_ff};
            wd0 = (op == c6502_pkg::OP_PHA) ? a_ff : (p_ff | c6502_pkg::FLAG_B);
            sp_in = sp_ff - 8'd1;
         end
         c6502_pkg::OP_PLA: begin sp_in = sp_ff + 8'd1; a_in = in_item.stack_byte_1; end
         c6502_pkg::OP_PLP: begin sp_in = sp_ff + 8'd1; pn = in_item.stack_byte_1; end
         default: ;
      endcase
      // N/Z on register results
      unique case (op)
         c6502_pkg::OP_AND, c6502_pkg::OP_EOR, c6502_pkg::OP_ORA, c6502_pkg::OP_ASLA,
         c6502_pkg::OP_LSRA, c6502_pkg::OP_ROLA, c6502_pkg::OP_RORA, c6502_pkg::OP_LDA,
         c6502_pkg::OP_TXA, c6502_pkg::OP_TYA, c6502_pkg::OP_PLA: begin
            pn[7] = a_in[7]; pn[1] = (a_in == 8'd0);
         end
         c6502_pkg::OP_LDX, c6502_pkg::OP_TAX, c6502_pkg::OP_DEX, c6502_pkg::OP_INX,
         c6502_pkg::OP_TSX: begin pn[7] = x_in[7]; pn[1] = (x_in == 8'd0); end
         c6502_pkg::OP_LDY, c6502_pkg::OP_TAY, c6502_pkg::OP_DEY,
         c6502_pkg::OP_INY: begin pn[7] = y_in[7]; pn[1] = (y_in == 8'd0); end
         default: ;
      endcase
      if (docmp) begin
         v = cmpreg - m;
         pn[7] = v[7]; pn[1] = (v == 8'd0); pn[0] = (m <= cmpreg);
      end
      p_in = pn;

      res_in.write_valid = (nw != 2'd0);
      res_in.last = (nw == 2'd0) || (beat_ff == nw - 2'd1);
      unique case (beat_ff)
         2'd0: begin res_in.write_address = wa0; res_in.write_data = wd0; end
         2'd1: begin res_in.write_address = wa1; res_in.write_data = wd1; end
         default: begin res_in.write_address = wa2; res_in.write_data = wd2; end
      endcase
      res_in.next_pc = nxt;
      res_in.acc_value = a_in;
      res_in.index_x_value = x_in;
      res_in.index_y_value = y_in;
      res_in.stack_pointer_value = sp_in;
      res_in.status_value = p_in;
      res_in.irq_request = irq;
      beat_in = res_in.last ? 2'd0 : beat_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 8'd0; x_ff <= 8'd0; y_ff <= 8'd0;
         sp_ff <= c6502_pkg::SP_RESET; p_ff <= c6502_pkg::P_RESET;
         beat_ff <= 2'd0; ov_ff <= 1'b0;
      end else begin
         if (load) begin
            beat_ff <= beat_in;
            ov_ff <= 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
         if (in_ready) begin
            a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; sp_ff <= sp_in; p_ff <= p_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res_in;
   end
endmodule
`default_nettype wire

### sv/cpu_6502_execute_unit_top.sv
`default_nettype none
// 6502 execute unit, binary arithmetic only.
// req_ channel: one decoded instruction per transfer, with its effective
//   address, the byte read there, three stack bytes above SP and the PC.
// rsp_ channel: one transfer per memory/stack write the instruction makes,
//   or a single transfer with write_valid low when it writes nothing.
//   tlast marks the final transfer of an instruction; register values are
//   the same on every transfer of one instruction.
// Path: a req_ transfer passes the queue entry, then the execute register,
//   before its first rsp_ transfer.
// Throughput: one instruction per cycle while rsp_tready is high; JSR and
//   BRK with I clear send one rsp_ transfer per write before the next one.
// Reset: A, X, Y clear, SP = 0xFD, P = 0x24, queue and output empty.
// When rsp_tready is low the result register holds, the execute stage
//   stops, and the two-entry queue fills before req_tready drops.
module cpu_6502_execute_unit_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // operation[5:0], operand_address[21:6], memory_byte[29:22],
   // stack_byte_1[37:30], stack_byte_2[45:38], stack_byte_3[53:46],
   // current_pc[69:54], zero fill to 72
   input  wire  [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // write_valid[0], write_address[16:1], write_data[24:17], next_pc[40:25],
   // acc_value[48:41], index_x_value[56:49], index_y_value[64:57],
   // stack_pointer_value[72:65], status_value[80:73], irq_request[81], fill to 88
   output logic [87:0] rsp_tdata,
   output logic        rsp_tlast
);
   c6502_pkg::instr_type  in_item, q_item;
   c6502_pkg::result_type res;
   logic q_valid, q_ready;

   assign in_item.operation       = req_tdata[5:0];
   assign in_item.operand_address = req_tdata[21:6];
   assign in_item.memory_byte     = req_tdata[29:22];
   assign in_item.stack_byte_1    = req_tdata[37:30];
   assign in_item.stack_byte_2    = req_tdata[45:38];
   assign in_item.stack_byte_3    = req_tdata[53:46];
   assign in_item.current_pc      = req_tdata[69:54];

   c6502_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   c6502_exec u_exec (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_item(res)
   );

   assign rsp_tlast = res.last;
   assign rsp_tdata = {6'd0, res.irq_request, res.status_value, res.stack_pointer_value,
                       res.index_y_value, res.index_x_value, res.acc_value, res.next_pc,
                       res.write_data, res.write_address, res.write_valid};
endmodule
`default_nettype wire
